### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the lookup cache RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TTL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lookup cache assertion failed");
`define TTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lookup cache assertion failed");
`else
`define TTL_ASSERT(label, clk, rst_n, prop)
`define TTL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/ttl_lfu_pkg.sv
// ----------------------------------------------------------------------------
// ttl_lfu_pkg
// Types, constants and helpers shared by the lookup cache and its cells.
// ----------------------------------------------------------------------------
package ttl_lfu_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int EL_W      = 7;
    localparam int ML_W      = 12;
    localparam int CFG_W     = 12;
    localparam int MIB_SHIFT = 20;
    localparam int CMP_W     = 40;
    localparam int USED_OUT_W = 23;
    localparam logic [EL_W-1:0] EL_RESET = 7'd64;
    localparam logic [ML_W-1:0] ML_RESET = 12'd4095;

    localparam logic [2:0] OP_PUT    = 3'd0;
    localparam logic [2:0] OP_GET    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;
    localparam logic [2:0] OP_SWEEP  = 3'd5;
    localparam logic [2:0] OP_STATS  = 3'd6;
    localparam logic [2:0] OP_NOP    = 3'd7;

    localparam logic CFG_ENTRY_LIMIT = 1'b0;
    localparam logic CFG_MEM_LIMIT   = 1'b1;

    typedef struct packed {
        logic [63:0] key;
        logic [15:0] typ;
        logic [31:0] ref_h;
        logic [7:0]  cnt;
        logic [15:0] size;
        logic [31:0] hits;
        logic [31:0] order;
        logic [31:0] expiry;
    } t_payload;

    typedef struct packed {
        logic     valid;
        t_payload data;
    } t_slot;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

### rtl/core/ttl_lfu_cell.sv
// ----------------------------------------------------------------------------
// ttl_lfu_cell
// One slot of the rotating table: takes its neighbour's entry on each shift.
// ----------------------------------------------------------------------------
module ttl_lfu_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic                 i_clear,
    input  ttl_lfu_pkg::t_slot   i_slot,
    output ttl_lfu_pkg::t_slot   o_slot
);

    logic                  r_valid;
    ttl_lfu_pkg::t_payload r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_slot.data;
        end
    end

    assign o_slot = '{valid: r_valid, data: r_data};

endmodule

### rtl/core/ttl_lfu_lookup_cache.sv
// ----------------------------------------------------------------------------
// ttl_lfu_lookup_cache
// Least-frequently-used lookup cache with TTL expiry, built as a ring of
// slot cells that rotates one place per cycle, while an operation walks it, past a single processing head.
//
//   channel  direction  handshake                  payload
//   in       to block   i_in_valid / o_in_ready    i_opcode .. i_entry_size
//   out      from block o_out_valid / i_out_ready  o_found .. o_evict_total
//   cfg      to block   i_cfg_we                   i_cfg_index, i_cfg_data
//
// A get, remove or sweep makes one full rotation of the ring.
// A put makes one rotation for each victim search, one for the key match and one
// for the store. Clear, tick, stats reset, the unused opcode and empty puts make
// no rotation and go straight to the result.
// Reset is synchronous and clears all valid bits at once.
// A result waits in the output register while the next transaction is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttl_lfu_lookup_cache #(
    parameter int TABLE_DEPTH = ttl_lfu_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_name_key,
    input  logic [15:0] i_record_type,
    input  logic [31:0] i_record_ref,
    input  logic [7:0]  i_record_count,
    input  logic [31:0] i_ttl_seconds,
    input  logic [15:0] i_entry_size,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [31:0] o_ttl_left,
    output logic [31:0] o_record_ref_out,
    output logic [7:0]  o_record_count_out,
    output logic [6:0]  o_evicted_now,
    output logic [6:0]  o_entry_count,
    output logic [22:0] o_memory_used,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_miss_total,
    output logic [31:0] o_evict_total,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [ttl_lfu_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int UWR = 16 + CW;
    localparam int UW  = (UWR > ttl_lfu_pkg::USED_OUT_W) ? UWR : ttl_lfu_pkg::USED_OUT_W;
    localparam int CPW = ttl_lfu_pkg::CMP_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_EVICT = 7'b0000100,
        S_MATCH = 7'b0001000,
        S_WRITE = 7'b0010000,
        S_SCAN  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0] r_step, n_step;
    logic [2:0]  r_op;
    logic [63:0] r_key;
    logic [15:0] r_typ;
    logic [31:0] r_ref;
    logic [7:0]  r_cnt;
    logic [31:0] r_ttl;
    logic [15:0] r_size;
    logic [ttl_lfu_pkg::EL_W-1:0] r_elim;
    logic [ttl_lfu_pkg::ML_W-1:0] r_mlim;

    logic [CW-1:0] r_count, n_count;
    logic [UW-1:0] r_used, n_used;
    logic [31:0] r_now, n_now, r_seq, n_seq;
    logic [31:0] r_hit, n_hit, r_miss, n_miss, r_evict, n_evict;

    logic r_pend, n_pend;
    logic [IW-1:0] r_pidx, n_pidx;
    logic r_vfound, n_vfound;
    logic [IW-1:0] r_vidx, n_vidx;
    logic [31:0] r_vhits, n_vhits, r_vorder, n_vorder;
    logic [15:0] r_vsize, n_vsize;
    logic r_mfound, n_mfound, r_ffound, n_ffound;
    logic [IW-1:0] r_fidx, n_fidx;

    logic r_found, n_found;
    logic [31:0] r_ttl_left, n_ttl_left, r_ref_o, n_ref_o;
    logic [7:0] r_cnt_o, n_cnt_o;
    logic [6:0] r_evicted, n_evicted;

    logic r_ov, n_ov;
    logic        r_o_found;
    logic [31:0] r_o_ttl, r_o_ref, r_o_hit, r_o_miss, r_o_evict;
    logic [7:0]  r_o_cnt;
    logic [6:0]  r_o_evn, r_o_entries;
    logic [22:0] r_o_used;
    logic        w_load_out;

    ttl_lfu_pkg::t_slot w_slot [TABLE_DEPTH];
    ttl_lfu_pkg::t_slot w_head;
    logic w_shift, w_clear;

    genvar gj;
    generate
        for (gj = 0; gj < TABLE_DEPTH; gj++) begin : g_ring
            if (gj == TABLE_DEPTH - 1) begin : g_tail
                ttl_lfu_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_clear (w_clear),
                    .i_slot  (w_head),
                    .o_slot  (w_slot[gj])
                );
            end else begin : g_body
                ttl_lfu_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_clear (w_clear),
                    .i_slot  (w_slot[gj+1]),
                    .o_slot  (w_slot[gj])
                );
            end
        end
    endgenerate

    logic        w_last, w_key_eq, w_expd, w_over_n, w_over_m, w_better;
    logic [31:0] w_lim, w_rem;
    logic [32:0] w_exp_sum;
    ttl_lfu_pkg::t_slot w_h;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_last     = (r_step == IW'(TABLE_DEPTH - 1));
    assign w_lim      = (32'(r_elim) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(r_elim);
    assign w_over_n   = 32'(r_count) >= w_lim;
    assign w_over_m   = (CPW'(r_used) + CPW'(r_size)) >
                        CPW'({r_mlim, {ttl_lfu_pkg::MIB_SHIFT{1'b0}}});
    assign w_exp_sum  = {1'b0, r_now} + {1'b0, r_ttl};

    always_comb begin
        n_state = r_state;   n_step = r_step;
        n_count = r_count;   n_used = r_used;
        n_now = r_now;       n_seq = r_seq;
        n_hit = r_hit;       n_miss = r_miss;   n_evict = r_evict;
        n_pend = r_pend;     n_pidx = r_pidx;
        n_vfound = r_vfound; n_vidx = r_vidx;   n_vhits = r_vhits;
        n_vorder = r_vorder; n_vsize = r_vsize;
        n_mfound = r_mfound; n_ffound = r_ffound; n_fidx = r_fidx;
        n_found = r_found;   n_ttl_left = r_ttl_left;
        n_ref_o = r_ref_o;   n_cnt_o = r_cnt_o; n_evicted = r_evicted;
        n_ov = r_ov && !i_out_ready;
        w_shift = 1'b0;      w_clear = 1'b0;    w_load_out = 1'b0;
        w_better = 1'b0;     w_rem = 32'd0;

        w_h = w_slot[0];
        if (r_pend && (r_step == r_pidx)) begin
            w_h.valid = 1'b0;
        end
        w_key_eq = w_h.valid && (w_h.data.key == r_key) && (w_h.data.typ == r_typ);
        w_expd   = r_now >= w_h.data.expiry;
        w_head   = w_h;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_found = 1'b0; n_ttl_left = 32'd0; n_ref_o = 32'd0;
                    n_cnt_o = 8'd0; n_evicted = 7'd0; n_pend = 1'b0;
                    n_vfound = 1'b0; n_mfound = 1'b0; n_ffound = 1'b0;
                    n_step = '0;
                    unique case (i_opcode)
                        ttl_lfu_pkg::OP_PUT: begin
                            n_state = (i_record_count != 8'd0 && i_ttl_seconds != 32'd0)
                                      ? S_CHECK : S_DONE;
                        end
                        ttl_lfu_pkg::OP_GET, ttl_lfu_pkg::OP_REMOVE,
                        ttl_lfu_pkg::OP_SWEEP: begin
                            n_state = S_SCAN;
                        end
                        ttl_lfu_pkg::OP_CLEAR: begin
                            w_clear = 1'b1; n_count = '0; n_used = '0; n_state = S_DONE;
                        end
                        ttl_lfu_pkg::OP_TICK: begin
                            n_now = ttl_lfu_pkg::sat_inc32(r_now); n_state = S_DONE;
                        end
                        ttl_lfu_pkg::OP_STATS: begin
                            n_hit = 32'd0; n_miss = 32'd0; n_evict = 32'd0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                n_vfound = 1'b0;
                n_step = '0;
                n_state = (r_count != '0 && (w_over_n || w_over_m)) ? S_EVICT : S_MATCH;
            end
            S_EVICT: begin
                w_shift = 1'b1;
                w_better = w_h.valid && (!r_vfound || w_h.data.hits < r_vhits ||
                           (w_h.data.hits == r_vhits && w_h.data.order < r_vorder));
                if (w_better) begin
                    n_vfound = 1'b1; n_vidx = r_step; n_vhits = w_h.data.hits;
                    n_vorder = w_h.data.order; n_vsize = w_h.data.size;
                end
                n_step = r_step + IW'(1);
                if (w_last) begin
                    n_step = '0;
                    n_state = S_CHECK;
                    n_pend = n_vfound;
                    n_pidx = n_vidx;
                    if (n_vfound) begin
                        n_count = r_count - CW'(1);
                        n_used = r_used - UW'(n_vsize);
                        n_evicted = r_evicted + 7'd1;
                        n_evict = ttl_lfu_pkg::sat_inc32(r_evict);
                    end
                end
            end
            S_MATCH: begin
                w_shift = 1'b1;
                if (w_key_eq && !r_mfound) begin
                    w_head.valid = 1'b0;
                    n_mfound = 1'b1;
                    n_count = r_count - CW'(1);
                    n_used = r_used - UW'(w_h.data.size);
                end
                if (!w_head.valid && !r_ffound) begin
                    n_ffound = 1'b1;
                    n_fidx = r_step;
                end
                n_step = r_step + IW'(1);
                if (w_last) begin
                    n_step = '0;
                    n_pend = 1'b0;
                    n_state = n_ffound ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: begin
                w_shift = 1'b1;
                if (r_step == r_fidx) begin
                    w_head.valid = 1'b1;
                    w_head.data.key = r_key;
                    w_head.data.typ = r_typ;
                    w_head.data.ref_h = r_ref;
                    w_head.data.cnt = r_cnt;
                    w_head.data.size = r_size;
                    w_head.data.hits = 32'd0;
                    w_head.data.order = r_seq;
                    w_head.data.expiry = w_exp_sum[32] ? 32'hFFFF_FFFF : w_exp_sum[31:0];
                    n_seq = ttl_lfu_pkg::sat_inc32(r_seq);
                    n_count = r_count + CW'(1);
                    n_used = r_used + UW'(r_size);
                end
                n_step = r_step + IW'(1);
                if (w_last) begin
                    n_step = '0;
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                w_shift = 1'b1;
                if (r_op == ttl_lfu_pkg::OP_SWEEP) begin
                    if (w_h.valid && w_expd) begin
                        w_head.valid = 1'b0;
                        n_count = r_count - CW'(1);
                        n_used = r_used - UW'(w_h.data.size);
                    end
                end else if (w_key_eq && !r_mfound) begin
                    n_mfound = 1'b1;
                    if (r_op == ttl_lfu_pkg::OP_REMOVE || w_expd) begin
                        w_head.valid = 1'b0;
                        n_count = r_count - CW'(1);
                        n_used = r_used - UW'(w_h.data.size);
                    end else begin
                        w_rem = w_h.data.expiry - r_now;
                        w_head.data.hits = ttl_lfu_pkg::sat_inc32(w_h.data.hits);
                        n_found = 1'b1;
                        n_ttl_left = (w_rem < 32'd1) ? 32'd1 : w_rem;
                        n_ref_o = w_h.data.ref_h;
                        n_cnt_o = w_h.data.cnt;
                    end
                end
                n_step = r_step + IW'(1);
                if (w_last) begin
                    n_step = '0;
                    n_state = S_DONE;
                    if (r_op == ttl_lfu_pkg::OP_GET) begin
                        if (n_found) begin
                            n_hit = ttl_lfu_pkg::sat_inc32(r_hit);
                        end else begin
                            n_miss = ttl_lfu_pkg::sat_inc32(r_miss);
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;   r_step <= '0;
            r_count <= '0;       r_used <= '0;
            r_now <= 32'd0;      r_seq <= 32'd0;
            r_hit <= 32'd0;      r_miss <= 32'd0;   r_evict <= 32'd0;
            r_pend <= 1'b0;      r_vfound <= 1'b0;
            r_mfound <= 1'b0;    r_ffound <= 1'b0;
            r_ov <= 1'b0;
            r_elim <= ttl_lfu_pkg::EL_RESET;
            r_mlim <= ttl_lfu_pkg::ML_RESET;
        end else begin
            r_state <= n_state;  r_step <= n_step;
            r_count <= n_count;  r_used <= n_used;
            r_now <= n_now;      r_seq <= n_seq;
            r_hit <= n_hit;      r_miss <= n_miss;  r_evict <= n_evict;
            r_pend <= n_pend;    r_vfound <= n_vfound;
            r_mfound <= n_mfound; r_ffound <= n_ffound;
            r_ov <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ttl_lfu_pkg::CFG_ENTRY_LIMIT: r_elim <= i_cfg_data[ttl_lfu_pkg::EL_W-1:0];
                    ttl_lfu_pkg::CFG_MEM_LIMIT:   r_mlim <= i_cfg_data[ttl_lfu_pkg::ML_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= n_pidx;   r_vidx <= n_vidx;   r_vhits <= n_vhits;
        r_vorder <= n_vorder; r_vsize <= n_vsize; r_fidx <= n_fidx;
        r_found <= n_found; r_ttl_left <= n_ttl_left;
        r_ref_o <= n_ref_o; r_cnt_o <= n_cnt_o; r_evicted <= n_evicted;
        if (o_in_ready && i_in_valid) begin
            r_op <= i_opcode;        r_key <= i_name_key;
            r_typ <= i_record_type;  r_ref <= i_record_ref;
            r_cnt <= i_record_count; r_ttl <= i_ttl_seconds;
            r_size <= i_entry_size;
        end
        if (w_load_out) begin
            r_o_found <= r_found;    r_o_ttl <= r_ttl_left;
            r_o_ref <= r_ref_o;      r_o_cnt <= r_cnt_o;
            r_o_evn <= r_evicted;    r_o_entries <= 7'(r_count);
            r_o_used <= r_used[ttl_lfu_pkg::USED_OUT_W-1:0];
            r_o_hit <= r_hit;        r_o_miss <= r_miss;
            r_o_evict <= r_evict;
        end
    end

    assign o_out_valid        = r_ov;
    assign o_found            = r_o_found;
    assign o_ttl_left         = r_o_ttl;
    assign o_record_ref_out   = r_o_ref;
    assign o_record_count_out = r_o_cnt;
    assign o_evicted_now      = r_o_evn;
    assign o_entry_count      = r_o_entries;
    assign o_memory_used      = r_o_used;
    assign o_hit_total        = r_o_hit;
    assign o_miss_total       = r_o_miss;
    assign o_evict_total      = r_o_evict;

    `TTL_ASSERT(a_count_bound, i_clk, i_rst_n, 32'(r_count) <= 32'(TABLE_DEPTH))
    `TTL_ASSERT(a_state_onehot, i_clk, i_rst_n, $onehot(r_state))
    `TTL_ASSERT(a_idle_aligned, i_clk, i_rst_n, (r_state != S_IDLE) || (r_step == '0))
    `TTL_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && o_in_ready,
                     r_state != S_IDLE)

endmodule
